FILE: hw/rtl/tls_pkg.sv
// Package for the task lifecycle supervisor: codes, widths, reset values and beat types.
`default_nettype none
package tls_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned SpanW   = 16;
  localparam int unsigned TaskW   = 4;
  localparam int unsigned OpW     = 3;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ReasonW = 2;
  localparam int unsigned ResW    = 2;
  localparam int unsigned FaultW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // operations
  localparam logic [OpW-1:0] OP_INIT   = 3'd0;
  localparam logic [OpW-1:0] OP_START  = 3'd1;
  localparam logic [OpW-1:0] OP_UPDATE = 3'd2;
  localparam logic [OpW-1:0] OP_STOP   = 3'd3;
  localparam logic [OpW-1:0] OP_RESET  = 3'd4;

  // modes
  localparam logic [ModeW-1:0] MODE_IDLE     = 3'd0;
  localparam logic [ModeW-1:0] MODE_STARTING = 3'd1;
  localparam logic [ModeW-1:0] MODE_RUNNING  = 3'd2;
  localparam logic [ModeW-1:0] MODE_STOPPING = 3'd3;
  localparam logic [ModeW-1:0] MODE_FINISHED = 3'd4;
  localparam logic [ModeW-1:0] MODE_FAULT    = 3'd5;

  // stop reasons
  localparam logic [ReasonW-1:0] REASON_NONE    = 2'd0;
  localparam logic [ReasonW-1:0] REASON_USER    = 2'd1;
  localparam logic [ReasonW-1:0] REASON_NATURAL = 2'd2;
  localparam logic [ReasonW-1:0] REASON_FAULT   = 2'd3;

  // port update answers
  localparam logic [ResW-1:0] RES_BUSY     = 2'd0;
  localparam logic [ResW-1:0] RES_FINISHED = 2'd1;
  localparam logic [ResW-1:0] RES_FAULT    = 2'd2;

  // fault detail for a stop that never settled
  localparam logic [FaultW-1:0] FAULT_STOP_TIMEOUT = 16'd1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_SETTLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STOP_SETTLE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STOP_TIMEOUT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_TASK = 2'd3;

  localparam logic [SpanW-1:0] START_SETTLE_RST = 16'd100;
  localparam logic [SpanW-1:0] STOP_SETTLE_RST  = 16'd100;
  localparam logic [SpanW-1:0] STOP_TIMEOUT_RST = 16'd2000;
  localparam logic [TaskW-1:0] DEFAULT_TASK_RST = 4'd0;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [TimeW-1:0]   now_ms;
    logic [TaskW-1:0]   task_code;
    logic [TimeW-1:0]   start_time_ms;
    logic [ReasonW-1:0] reason_in;
    logic               port_ok;
    logic [ResW-1:0]    port_result;
    logic               port_stopped;
    logic [FaultW-1:0]  port_fault_code;
  } evt_t;

  typedef struct packed {
    logic               accepted;
    logic [ModeW-1:0]   mode;
    logic [ReasonW-1:0] stop_cause;
    logic [TaskW-1:0]   current_task;
    logic [TimeW-1:0]   elapsed_out;
    logic [FaultW-1:0]  fault_info;
    logic [TimeW-1:0]   tick_count;
    logic               force_safe_stop;
    logic               port_reset_req;
    logic               port_start_req;
    logic               port_stop_req;
    logic               port_update_req;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tls_in_if.sv
// Event channel of the task lifecycle supervisor.
`default_nettype none
interface tls_in_if;
  logic                             valid;
  logic                             ready;
  logic [tls_pkg::OpW-1:0]          operation;
  logic [tls_pkg::TimeW-1:0]        now_ms;
  logic [tls_pkg::TaskW-1:0]        task_code;
  logic [tls_pkg::TimeW-1:0]        start_time_ms;
  logic [tls_pkg::ReasonW-1:0]      reason_in;
  logic                             port_ok;
  logic [tls_pkg::ResW-1:0]         port_result;
  logic                             port_stopped;
  logic [tls_pkg::FaultW-1:0]       port_fault_code;

  modport source (
    output valid, operation, now_ms, task_code, start_time_ms, reason_in,
           port_ok, port_result, port_stopped, port_fault_code,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, task_code, start_time_ms, reason_in,
           port_ok, port_result, port_stopped, port_fault_code,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/tls_out_if.sv
// Result channel of the task lifecycle supervisor.
`default_nettype none
interface tls_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [tls_pkg::ModeW-1:0]   mode;
  logic [tls_pkg::ReasonW-1:0] stop_cause;
  logic [tls_pkg::TaskW-1:0]   current_task;
  logic [tls_pkg::TimeW-1:0]   elapsed_out;
  logic [tls_pkg::FaultW-1:0]  fault_info;
  logic [tls_pkg::TimeW-1:0]   tick_count;
  logic                        force_safe_stop;
  logic                        port_reset_req;
  logic                        port_start_req;
  logic                        port_stop_req;
  logic                        port_update_req;

  modport source (
    output valid, accepted, mode, stop_cause, current_task, elapsed_out, fault_info,
           tick_count, force_safe_stop, port_reset_req, port_start_req,
           port_stop_req, port_update_req,
    input  ready
  );
  modport sink (
    input  valid, accepted, mode, stop_cause, current_task, elapsed_out, fault_info,
           tick_count, force_safe_stop, port_reset_req, port_start_req,
           port_stop_req, port_update_req,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/task_lifecycle_supervisor.sv
// Task lifecycle supervisor: event register, mode logic, result register.
//
//  channel  | dir | handshake      | beat
//  ---------+-----+----------------+-------------------------------------------
//  in_bus   | in  | valid/ready    | one event: operation, time, port answers
//  out_bus  | out | valid/ready    | one result: mode, status, port pulses
//  cfg_*    | in  | cfg_we only    | register index and 16-bit data, no stall
//
// One event per cycle while out_bus is ready; an accepted event passes the event
// register, then the result register. The mode/status registers update in the
// same cycle the result register loads, so the next event sees them at once.
// Synchronous reset loads the configuration defaults and an idle, unready task.
// A stalled output fills the event register, then drops in_bus.ready.
`default_nettype none
module task_lifecycle_supervisor (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tls_in_if.sink                              in_bus,
  tls_out_if.source                           out_bus,
  input  wire logic                           cfg_we,
  input  wire logic [tls_pkg::CfgIdxW-1:0]    cfg_idx,
  input  wire logic [tls_pkg::CfgDataW-1:0]   cfg_wdata
);

  // configuration
  logic [tls_pkg::SpanW-1:0] start_settle_r, stop_settle_r, stop_timeout_r;
  logic [tls_pkg::TaskW-1:0] default_task_r;

  // pipeline control
  logic                 evt_v_r, res_v_r;
  tls_pkg::evt_t        evt_r;
  tls_pkg::res_t        res_r, res_nxt;
  logic                 advance, in_fire;

  // task state
  logic                        ready_r, ready_nxt;
  logic [tls_pkg::ModeW-1:0]   mode_r, mode_nxt;
  logic [tls_pkg::TaskW-1:0]   task_r, task_nxt;
  logic [tls_pkg::ReasonW-1:0] reason_r, reason_nxt;
  logic [tls_pkg::TimeW-1:0]   tstart_r, tstart_nxt;
  logic [tls_pkg::TimeW-1:0]   entry_r, entry_nxt;
  logic [tls_pkg::TimeW-1:0]   elapsed_r, elapsed_nxt;
  logic [tls_pkg::TimeW-1:0]   count_r, count_nxt;
  logic [tls_pkg::FaultW-1:0]  fault_r, fault_nxt;

  logic [tls_pkg::TimeW-1:0] in_mode;
  logic start_done, stop_settled, stop_expired;
  logic acc, force_stop, rst_req, start_req, stop_req, upd_req;

  assign advance      = !res_v_r || out_bus.ready;
  assign in_bus.ready = !evt_v_r || advance;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_settle_r <= tls_pkg::START_SETTLE_RST;
      stop_settle_r  <= tls_pkg::STOP_SETTLE_RST;
      stop_timeout_r <= tls_pkg::STOP_TIMEOUT_RST;
      default_task_r <= tls_pkg::DEFAULT_TASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tls_pkg::CFG_START_SETTLE: start_settle_r <= cfg_wdata;
        tls_pkg::CFG_STOP_SETTLE:  stop_settle_r  <= cfg_wdata;
        tls_pkg::CFG_STOP_TIMEOUT: stop_timeout_r <= cfg_wdata;
        tls_pkg::CFG_DEFAULT_TASK: default_task_r <= cfg_wdata[tls_pkg::TaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      evt_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      evt_r.operation       <= in_bus.operation;
      evt_r.now_ms          <= in_bus.now_ms;
      evt_r.task_code       <= in_bus.task_code;
      evt_r.start_time_ms   <= in_bus.start_time_ms;
      evt_r.reason_in       <= in_bus.reason_in;
      evt_r.port_ok         <= in_bus.port_ok;
      evt_r.port_result     <= in_bus.port_result;
      evt_r.port_stopped    <= in_bus.port_stopped;
      evt_r.port_fault_code <= in_bus.port_fault_code;
    end
  end

  // wrapping time spent in the current mode
  assign in_mode      = evt_r.now_ms - entry_r;
  assign start_done   = in_mode >= {{(tls_pkg::TimeW-tls_pkg::SpanW){1'b0}}, start_settle_r};
  assign stop_settled = in_mode >= {{(tls_pkg::TimeW-tls_pkg::SpanW){1'b0}}, stop_settle_r};
  assign stop_expired = in_mode >= {{(tls_pkg::TimeW-tls_pkg::SpanW){1'b0}}, stop_timeout_r};

  always_comb begin
    ready_nxt   = ready_r;
    mode_nxt    = mode_r;
    task_nxt    = task_r;
    reason_nxt  = reason_r;
    tstart_nxt  = tstart_r;
    entry_nxt   = entry_r;
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    fault_nxt   = fault_r;
    acc         = 1'b0;
    force_stop  = 1'b0;
    rst_req     = 1'b0;
    start_req   = 1'b0;
    stop_req    = 1'b0;
    upd_req     = 1'b0;

    unique case (evt_r.operation) inside
      tls_pkg::OP_INIT, tls_pkg::OP_RESET: begin
        mode_nxt    = tls_pkg::MODE_IDLE;
        task_nxt    = default_task_r;
        reason_nxt  = tls_pkg::REASON_NONE;
        tstart_nxt  = '0;
        entry_nxt   = evt_r.now_ms;
        elapsed_nxt = '0;
        count_nxt   = '0;
        fault_nxt   = '0;
        if (evt_r.operation == tls_pkg::OP_INIT) begin
          ready_nxt  = evt_r.port_ok;
          acc        = evt_r.port_ok;
          force_stop = !evt_r.port_ok;
        end else begin
          rst_req = 1'b1;
        end
      end
      tls_pkg::OP_START: begin
        if (ready_r && (mode_r == tls_pkg::MODE_IDLE || mode_r == tls_pkg::MODE_FINISHED)) begin
          rst_req   = 1'b1;
          start_req = 1'b1;
          if (!evt_r.port_ok) begin
            force_stop = 1'b1;
            fault_nxt  = evt_r.port_fault_code;
            mode_nxt   = tls_pkg::MODE_FAULT;
            entry_nxt  = evt_r.now_ms;
          end else begin
            task_nxt    = evt_r.task_code;
            reason_nxt  = tls_pkg::REASON_NONE;
            tstart_nxt  = evt_r.start_time_ms;
            elapsed_nxt = '0;
            count_nxt   = '0;
            fault_nxt   = '0;
            mode_nxt    = tls_pkg::MODE_STARTING;
            entry_nxt   = evt_r.start_time_ms;
            acc         = 1'b1;
          end
        end
      end
      tls_pkg::OP_UPDATE: begin
        if (ready_r) begin
          count_nxt = count_r + 32'd1;
          if (mode_r == tls_pkg::MODE_STARTING || mode_r == tls_pkg::MODE_RUNNING ||
              (mode_r == tls_pkg::MODE_STOPPING && reason_r != tls_pkg::REASON_NATURAL)) begin
            elapsed_nxt = evt_r.now_ms - tstart_r;
          end
          if (mode_r == tls_pkg::MODE_STARTING) begin
            if (start_done) begin
              mode_nxt  = tls_pkg::MODE_RUNNING;
              entry_nxt = evt_r.now_ms;
            end
          end else if (mode_r == tls_pkg::MODE_RUNNING) begin
            upd_req = 1'b1;
            if (evt_r.port_result == tls_pkg::RES_FINISHED) begin
              reason_nxt = tls_pkg::REASON_NATURAL;
              stop_req   = 1'b1;
              entry_nxt  = evt_r.now_ms;
              if (!evt_r.port_ok) begin
                force_stop = 1'b1;
                fault_nxt  = evt_r.port_fault_code;
                mode_nxt   = tls_pkg::MODE_FAULT;
              end else begin
                mode_nxt = tls_pkg::MODE_STOPPING;
              end
            end else if (evt_r.port_result == tls_pkg::RES_FAULT) begin
              reason_nxt = tls_pkg::REASON_FAULT;
              fault_nxt  = evt_r.port_fault_code;
              force_stop = 1'b1;
              mode_nxt   = tls_pkg::MODE_FAULT;
              entry_nxt  = evt_r.now_ms;
            end
          end else if (mode_r == tls_pkg::MODE_STOPPING) begin
            upd_req = 1'b1;
            // port fault wins over settle, settle wins over timeout
            if (evt_r.port_result == tls_pkg::RES_FAULT) begin
              reason_nxt = tls_pkg::REASON_FAULT;
              fault_nxt  = evt_r.port_fault_code;
              force_stop = 1'b1;
              mode_nxt   = tls_pkg::MODE_FAULT;
              entry_nxt  = evt_r.now_ms;
            end else if (evt_r.port_stopped && stop_settled) begin
              mode_nxt  = tls_pkg::MODE_FINISHED;
              entry_nxt = evt_r.now_ms;
            end else if (stop_expired) begin
              fault_nxt  = tls_pkg::FAULT_STOP_TIMEOUT;
              force_stop = 1'b1;
              mode_nxt   = tls_pkg::MODE_FAULT;
              entry_nxt  = evt_r.now_ms;
            end
          end
        end
      end
      tls_pkg::OP_STOP: begin
        if (ready_r) begin
          if (mode_r == tls_pkg::MODE_STOPPING) begin
            acc = 1'b1;
          end else if (mode_r == tls_pkg::MODE_STARTING || mode_r == tls_pkg::MODE_RUNNING) begin
            stop_req  = 1'b1;
            entry_nxt = evt_r.now_ms;
            if (!evt_r.port_ok) begin
              force_stop = 1'b1;
              fault_nxt  = evt_r.port_fault_code;
              mode_nxt   = tls_pkg::MODE_FAULT;
            end else begin
              reason_nxt = evt_r.reason_in;
              mode_nxt   = tls_pkg::MODE_STOPPING;
              acc        = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    res_nxt.accepted        = acc;
    res_nxt.mode            = mode_nxt;
    res_nxt.stop_cause      = reason_nxt;
    res_nxt.current_task    = task_nxt;
    res_nxt.elapsed_out     = elapsed_nxt;
    res_nxt.fault_info      = fault_nxt;
    res_nxt.tick_count      = count_nxt;
    res_nxt.force_safe_stop = force_stop;
    res_nxt.port_reset_req  = rst_req;
    res_nxt.port_start_req  = start_req;
    res_nxt.port_stop_req   = stop_req;
    res_nxt.port_update_req = upd_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= 1'b0;
      mode_r    <= tls_pkg::MODE_IDLE;
      task_r    <= tls_pkg::DEFAULT_TASK_RST;
      reason_r  <= tls_pkg::REASON_NONE;
      tstart_r  <= '0;
      entry_r   <= '0;
      elapsed_r <= '0;
      count_r   <= '0;
      fault_r   <= '0;
      res_v_r   <= 1'b0;
    end else if (advance) begin
      res_v_r <= evt_v_r;
      if (evt_v_r) begin
        ready_r   <= ready_nxt;
        mode_r    <= mode_nxt;
        task_r    <= task_nxt;
        reason_r  <= reason_nxt;
        tstart_r  <= tstart_nxt;
        entry_r   <= entry_nxt;
        elapsed_r <= elapsed_nxt;
        count_r   <= count_nxt;
        fault_r   <= fault_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid           = res_v_r;
  assign out_bus.accepted        = res_r.accepted;
  assign out_bus.mode            = res_r.mode;
  assign out_bus.stop_cause      = res_r.stop_cause;
  assign out_bus.current_task    = res_r.current_task;
  assign out_bus.elapsed_out     = res_r.elapsed_out;
  assign out_bus.fault_info      = res_r.fault_info;
  assign out_bus.tick_count      = res_r.tick_count;
  assign out_bus.force_safe_stop = res_r.force_safe_stop;
  assign out_bus.port_reset_req  = res_r.port_reset_req;
  assign out_bus.port_start_req  = res_r.port_start_req;
  assign out_bus.port_stop_req   = res_r.port_stop_req;
  assign out_bus.port_update_req = res_r.port_update_req;

`ifndef ASSERT_OFF
  // an unready supervisor can only sit idle
  a_unready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_r |-> mode_r == tls_pkg::MODE_IDLE)
    else $error("unready supervisor left idle");

  // a start request always comes with a port reset
  a_start_with_reset: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && res_r.port_start_req |-> res_r.port_reset_req)
    else $error("start request without port reset");

  // an accepted call never forces a safe stop
  a_acc_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> !(res_r.accepted && res_r.force_safe_stop))
    else $error("accepted beat also forces safe stop");

  // an empty result stage never backs up the event side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !res_v_r |-> in_bus.ready)
    else $error("event side stalled with empty result stage");
`endif

endmodule
`default_nettype wire
